@@ rtl/core/swtb_pkg.sv @@
// Shared types and constants for the software timer bank.
package swtb_pkg;

    localparam int TIMER_SLOTS_DEF = 8;
    localparam int MASK_W          = 8;
    localparam int SLOT_W          = 3;
    localparam int PERIOD_W        = 32;
    localparam int STEP_W          = 16;
    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd100;

    // Request opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;

    typedef struct packed {
        logic [2:0]          opcode;
        logic [SLOT_W-1:0]   timer_slot;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
    } t_req;

    typedef struct packed {
        logic [MASK_W-1:0] fired_mask;
        logic [SLOT_W-1:0] created_slot;
        logic              create_failed;
    } t_rsp;

    // Request token passed from cell to cell
    typedef struct packed {
        logic [2:0]          opcode;
        logic [SLOT_W-1:0]   timer_slot;
        logic [PERIOD_W-1:0] period;
        logic                periodic;
        logic                claimed;
        logic [SLOT_W-1:0]   created_slot;
        logic [MASK_W-1:0]   fired_mask;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_ctl_state;

endpackage

@@ rtl/core/swtb_cell.sv @@
// One timer slot: holds its state and updates it as the request token passes.
module swtb_cell
    import swtb_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [STEP_W-1:0] i_step,
    input  logic              i_tok_valid,
    input  t_tok              i_tok,
    output logic              o_tok_valid,
    output t_tok              o_tok
);

    localparam logic [MASK_W-1:0] FIRE_BIT =
        (INDEX < MASK_W) ? MASK_W'(1 << (INDEX % MASK_W)) : '0;
    localparam logic [SLOT_W-1:0] IDX_CODE = SLOT_W'(INDEX % (1 << SLOT_W));
    localparam logic ADDRESSABLE = (INDEX < (1 << SLOT_W));

    logic                r_used, n_used;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PERIOD_W-1:0] r_remain, n_remain;
    logic                r_periodic, n_periodic;
    logic                r_tok_valid;
    t_tok                r_tok, n_tok;
    logic                w_hit;

    assign w_hit = ADDRESSABLE && (i_tok.timer_slot == IDX_CODE) && r_used;

    always_comb begin
        n_used     = r_used;
        n_period   = r_period;
        n_remain   = r_remain;
        n_periodic = r_periodic;
        n_tok      = i_tok;
        if (i_tok_valid) begin
            case (i_tok.opcode)
                OP_TICK: begin
                    if (r_used && (r_remain != '0)) begin
                        if (r_remain <= {{(PERIOD_W-STEP_W){1'b0}}, i_step}) begin
                            n_remain         = r_periodic ? r_period : '0;
                            n_tok.fired_mask = i_tok.fired_mask | FIRE_BIT;
                        end else begin
                            n_remain = r_remain - {{(PERIOD_W-STEP_W){1'b0}}, i_step};
                        end
                    end
                end
                OP_CREATE: begin
                    if (!i_tok.claimed && !r_used) begin
                        n_used             = 1'b1;
                        n_period           = i_tok.period;
                        n_remain           = i_tok.period;
                        n_periodic         = i_tok.periodic;
                        n_tok.claimed      = 1'b1;
                        n_tok.created_slot = IDX_CODE;
                    end
                end
                OP_START: begin
                    if (w_hit) n_remain = r_period;
                end
                OP_STOP: begin
                    if (w_hit) n_remain = '0;
                end
                OP_DELETE: begin
                    if (w_hit) n_used = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_tok_valid <= i_tok_valid;
        end
        r_period   <= n_period;
        r_remain   <= n_remain;
        r_periodic <= n_periodic;
        r_tok      <= n_tok;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

@@ rtl/core/software_timer_bank.sv @@
// Top level of the software timer bank: request control, config register, cell chain.
// Path from request accept to result valid: head register, one register per slot cell as
//   the request token walks the chain one cell per cycle, result register, output register.
// One request at a time: input stalls while a request walks and until its result is loaded for output.
// Reset (synchronous, active low): all slots free, tick step 100 ms, no result pending.
module software_timer_bank
    import swtb_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_req        i_in_req,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_rsp        o_out_rsp,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Word index of the tick step register (byte address 0)
    localparam logic REG_TICK_STEP = 1'b0;

    t_ctl_state        r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              r_head_valid;
    t_tok              r_head;
    t_rsp              r_res;
    logic              r_out_valid;
    t_rsp              r_out;

    logic w_accept;
    logic w_out_load;
    logic w_cfg_wr;

    // Token wires along the chain: index 0 is the head, TIMER_SLOTS is the tail
    logic w_vld [0:TIMER_SLOTS];
    t_tok w_tok [0:TIMER_SLOTS];

    // ---------------- config register ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TICK_STEP);
    assign prdata   = (paddr[2] == REG_TICK_STEP) ? {16'd0, r_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= TICK_STEP_RESET;
        end else if (w_cfg_wr) begin
            r_step <= pwdata[STEP_W-1:0];
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_WALK;
            ST_WALK: if (w_vld[TIMER_SLOTS]) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_WALK: o_in_stall = 1'b1;
            ST_DONE: w_out_load = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= w_accept;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // head token: fresh request with empty result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head.opcode       <= i_in_req.opcode;
            r_head.timer_slot   <= i_in_req.timer_slot;
            r_head.period       <= i_in_req.period;
            r_head.periodic     <= i_in_req.periodic;
            r_head.claimed      <= 1'b0;
            r_head.created_slot <= '0;
            r_head.fired_mask   <= '0;
        end
    end

    assign w_vld[0] = r_head_valid;
    assign w_tok[0] = r_head;

    // ---------------- slot cells ----------------
    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        swtb_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (r_step),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    // ---------------- result ----------------
    // Capture the tail token; a create that no cell claimed failed.
    always_ff @(posedge i_clk) begin
        if (w_vld[TIMER_SLOTS]) begin
            r_res.fired_mask    <= w_tok[TIMER_SLOTS].fired_mask;
            r_res.created_slot  <= w_tok[TIMER_SLOTS].created_slot;
            r_res.create_failed <= (w_tok[TIMER_SLOTS].opcode == OP_CREATE) &&
                                   !w_tok[TIMER_SLOTS].claimed;
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
